// ----- rtl/core/b2d_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared widths, character codes and controller/datapath handshake types
// for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 6;
    localparam int COUNT_W = 5;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    typedef struct packed {
        logic load;
        logic shift;
        logic measure;
        logic emit;
    } b2d_cmd_t;

    typedef struct packed {
        logic bits_done;
        logic last;
    } b2d_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/b2d_value_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_value_if
// Input channel: one unsigned binary word per handshake.
// ----------------------------------------------------------------------------
interface b2d_value_if
    import b2d_pkg::*;
();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/b2d_digit_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_digit_if
// Output channel: one ASCII decimal digit per word, with run length and
// end-of-run flag.
// ----------------------------------------------------------------------------
interface b2d_digit_if
    import b2d_pkg::*;
();

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               last_digit;

    modport source (output valid, output digit_char, output digit_count,
                    output last_digit, input ready);
    modport sink   (input valid, input digit_char, input digit_count,
                    input last_digit, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/b2d_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_ctrl
// Sequencer: load, shift-add-3 over every input bit, measure digit count,
// then hand out digits through the output register.
// ----------------------------------------------------------------------------
module b2d_ctrl
    import b2d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire b2d_status_t status,
    output b2d_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SHIFT   = 2'd1;
    localparam logic [1:0] ST_MEASURE = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.bits_done)
                begin
                    state_next = ST_MEASURE;
                end
            end
            ST_MEASURE:
            begin
                cmd.measure = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/b2d_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_datapath
// Double-dabble BCD register, bit and digit counters, leading-zero measure
// and the output payload register.
// ----------------------------------------------------------------------------
module b2d_datapath
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  wire logic               clk,
    input  wire b2d_cmd_t           cmd,
    input  wire logic [VALUE_W-1:0] value,
    output b2d_status_t             status,
    output logic [CHAR_W-1:0]       digit_char,
    output logic [COUNT_W-1:0]      digit_count,
    output logic                    last_digit
);

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [3:0]            bcd_reg [NUM_DIGITS];
    logic [3:0]            bcd_adj [NUM_DIGITS];
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [DIG_IDX_W-1:0]  k_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_meas;
    logic [DIG_IDX_W-1:0]  sel_idx;
    logic [3:0]            sel_digit;
    logic [CHAR_W-1:0]     char_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic                  last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        count_meas = COUNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                count_meas = COUNT_W'(i + 1);
            end
        end
    end

    assign sel_idx   = DIG_IDX_W'(count_reg - COUNT_W'(1) - COUNT_W'(k_reg));
    assign sel_digit = bcd_reg[sel_idx];

    assign status.bits_done = (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
    assign status.last      = (COUNT_W'(k_reg) == count_reg - COUNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg     <= value[VALUE_BITS-1:0];
            bit_cnt_reg <= '0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        else if (cmd.shift)
        begin
            bin_reg     <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            bcd_reg[0]  <= {bcd_adj[0][2:0], bin_reg[VALUE_BITS-1]};
            for (int i = 1; i < NUM_DIGITS; i++)
            begin
                bcd_reg[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
            end
        end

        if (cmd.measure)
        begin
            count_reg <= count_meas;
            k_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + DIG_IDX_W'(1);
        end

        if (cmd.emit)
        begin
            char_reg      <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, sel_digit};
            count_out_reg <= count_reg;
            last_reg      <= status.last;
        end
    end

    assign digit_char  = char_reg;
    assign digit_count = count_out_reg;
    assign last_digit  = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/binary_to_decimal_ascii_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned binary word to its decimal ASCII text, most
// significant digit first, no leading zeros.
//
//   Channel    Dir   Word contents
//   value_ch   in    value[63:0] (low VALUE_BITS bits used)
//   digit_ch   out   digit_char[5:0], digit_count[4:0], last_digit
//
// One word in runs as one load, one shift-add-3 step per input bit, one
// digit-count measure, then one digit per cycle while the output is not
// stalled.
// A finished digit waits in the output register; a stalled output stops
// digit issue only. value_ch reopens once the final digit is registered.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit
    import b2d_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    b2d_value_if.sink  value_ch,
    b2d_digit_if.source digit_ch
);

    b2d_cmd_t    cmd;
    b2d_status_t status;

    b2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (value_ch.valid),
        .in_ready  (value_ch.ready),
        .out_valid (digit_ch.valid),
        .out_ready (digit_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    b2d_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .value       (value_ch.value),
        .status      (status),
        .digit_char  (digit_ch.digit_char),
        .digit_count (digit_ch.digit_count),
        .last_digit  (digit_ch.last_digit)
    );

endmodule

`default_nettype wire

// ----- tb/tb_binary_to_decimal_ascii_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_unit
// Self-checking bench for the binary to decimal ASCII converter. Drives
// 64-bit words with random gaps and output back-pressure, predicts the
// digit text of every accepted word, and checks each digit word in order.
// The bench runs directed edge values, random values of every length, bursts
// separated by a full drain, and a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_unit;

    import b2d_pkg::*;

    localparam int          VALUE_BITS  = 64;
    localparam int          MAX_DIGITS  = 20;
    localparam int          IDLE_PCT    = 32;
    localparam int          TAIL_CYCLES = 120;
    localparam int          MAX_REPORTS = 40;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << VALUE_BITS) - 1);

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
        logic               last;
    } digit_word_t;

    logic clk;
    logic rst_n;
    logic steady;

    int          error_count;
    int unsigned cycle_count;
    digit_word_t expected_digits[$];

    b2d_value_if value_bus ();
    b2d_digit_if digit_bus ();

    binary_to_decimal_ascii_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_bus),
        .digit_ch (digit_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("binary_to_decimal_ascii_unit: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        digit_bus.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
        begin
            $display("ERROR %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic queue_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [3:0]         rev [MAX_DIGITS];
        int                 n;
        digit_word_t        w;
        rest = value & VALUE_MASK;
        n    = 0;
        if (rest == 0)
        begin
            rev[0] = 4'd0;
            n      = 1;
        end
        while (rest != 0 && n < MAX_DIGITS)
        begin
            rev[n] = 4'(rest % 10);
            rest   = rest / 10;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            w.ch    = ASCII_ZERO + CHAR_W'(rev[n - 1 - k]);
            w.count = COUNT_W'(n);
            w.last  = (k == n - 1);
            expected_digits.push_back(w);
        end
    endtask

    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n && digit_bus.valid && digit_bus.ready)
        begin
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit word char=%0d count=%0d last=%0b",
                    digit_bus.digit_char, digit_bus.digit_count, digit_bus.last_digit));
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit_bus.digit_char !== want.ch)
                begin
                    report_mismatch($sformatf("digit_char %0d, want %0d",
                        digit_bus.digit_char, want.ch));
                end
                if (digit_bus.digit_count !== want.count)
                begin
                    report_mismatch($sformatf("digit_count %0d, want %0d",
                        digit_bus.digit_count, want.count));
                end
                if (digit_bus.last_digit !== want.last)
                begin
                    report_mismatch($sformatf("last_digit %0b, want %0b",
                        digit_bus.last_digit, want.last));
                end
            end
        end
    end

    // enter and leave at a falling edge
    task automatic send_value(input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            value_bus.valid = 1'b0;
            @(negedge clk);
        end
        value_bus.valid = 1'b1;
        value_bus.value = value;
        do
        begin
            @(posedge clk);
        end
        while (!value_bus.ready);
        queue_decimal_digits(value);
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        value_bus.valid = 1'b0;
        while (expected_digits.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] power_of_ten(input int k);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 pick;
        int                 width;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            v = '0;
        end
        else if (pick < 20)
        begin
            v = power_of_ten($urandom_range(1, 19)) + VALUE_W'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            width = $urandom_range(1, VALUE_W);
            v     = {$urandom, $urandom};
            if (width < VALUE_W)
            begin
                v = v & ((VALUE_W'(1) << width) - 1);
            end
        end
        return v;
    endfunction

    task automatic test_directed_values();
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'd999_999_999);
        send_value(64'd1_000_000_000);
        send_value(64'hFFFF_FFFF);
        send_value(64'h1_0000_0000);
        send_value(64'd9_999_999_999_999_999_999);
        send_value(64'd10_000_000_000_000_000_000);
        send_value(64'd12_345_678_901_234_567_890);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd0);
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_value(random_value());
        end
    endtask

    task automatic test_drain_between_bursts();
        for (int b = 0; b < 4; b++)
        begin
            for (int i = 0; i < 10; i++)
            begin
                send_value(random_value());
            end
            wait_until_drained();
        end
    endtask

    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            send_value(random_value());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        steady          = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        value_bus.valid = 1'b0;
        value_bus.value = '0;
        digit_bus.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_values();
        test_random_values(240);
        test_drain_between_bursts();
        test_steady_stream(60);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_digits.size() == 0)
        begin
            $display("binary_to_decimal_ascii_unit: match");
        end
        else
        begin
            $display("binary_to_decimal_ascii_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/b2d_pkg.sv
rtl/core/b2d_value_if.sv
rtl/core/b2d_digit_if.sv
rtl/core/b2d_ctrl.sv
rtl/core/b2d_datapath.sv
rtl/core/binary_to_decimal_ascii_unit.sv
tb/tb_binary_to_decimal_ascii_unit.sv
